// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the GF(2^8) unit RTL; included by gf256_arithmetic_unit.
// Expects aclk and aresetn in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every rising clock edge outside reset.
`define GFAU_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define GFAU_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define GFAU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/gfau_pkg.sv =====
// Types, codes and GF(2^8) helper functions for the arithmetic unit.
// No dependencies; used by gfau_stage and gf256_arithmetic_unit.
package gfau_pkg;

    localparam int NUM_STAGES = 5;

    // AES reduction polynomial x^8+x^4+x^3+x+1, including the x^8 term.
    localparam logic [8:0] GF_POLY = 9'h11B;
    localparam logic [7:0] GF_ONE  = 8'h01;
    localparam logic [7:0] GF_ZERO = 8'h00;

    typedef enum logic [1:0] {
        FUNC_ADD = 2'd0,
        FUNC_SUB = 2'd1,
        FUNC_MUL = 2'd2,
        FUNC_DIV = 2'd3
    } func_t;

    typedef struct packed {
        func_t      func;
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] acc;
        logic       dz;
    } item_t;

    // Reduce a 15-bit carry-less product modulo the field polynomial.
    function automatic logic [7:0] gf_reduce(input logic [14:0] p);
        logic [14:0] r;
        r = p;
        for (int i = 14; i >= 8; i--) begin
            if (r[i]) begin
                r = r ^ (15'(GF_POLY) << (i - 8));
            end
        end
        return r[7:0];
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] x, input logic [7:0] y);
        logic [14:0] p;
        p = '0;
        for (int i = 0; i < 8; i++) begin
            if (y[i]) begin
                p = p ^ (15'(x) << i);
            end
        end
        return gf_reduce(p);
    endfunction

    // Squaring is linear over GF(2): spread the bits, then reduce.
    function automatic logic [7:0] gf_sq(input logic [7:0] x);
        logic [14:0] p;
        p = '0;
        for (int i = 0; i < 8; i++) begin
            p[2*i] = x[i];
        end
        return gf_reduce(p);
    endfunction

endpackage

// ===== hw/rtl/gf256_arithmetic_unit.sv =====
// GF(2^8) arithmetic unit (AES polynomial 0x11B): add, subtract, multiply, divide.
// Throughput: one beat per cycle while m_ready stays high; beats pass through the stage
// registers in order, and each of the five stages holds one field multiplier.
// Reset: synchronous, active-low aresetn clears every stage valid bit; data is not reset.
// Depends on gfau_pkg, gfau_stage and assert_macros.svh.
`include "assert_macros.svh"

module gf256_arithmetic_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_func,
    input  logic [7:0] s_operand_a,
    input  logic [7:0] s_operand_b,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_result,
    output logic       m_divide_by_zero
);

    // The divisor inverse is b^254 = (b^127)^2, built by an addition chain:
    //   stage 0: b^3   = b^2 * b
    //   stage 1: b^7   = (b^3)^2 * b
    //   stage 2: b^63  = (b^7)^8 * b^7
    //   stage 3: b^127 = (b^63)^2 * b
    //   stage 4: a * (b^127)^2 for divide, a * b for multiply, a ^ b for add/sub
    // Squarings are XOR networks; each stage holds a single multiplier.
    // For b == 0 the chain yields 0, so the quotient is already 0.

    localparam int N = gfau_pkg::NUM_STAGES;

    logic            stage_valid [0:N];
    logic            stage_ready [0:N];
    gfau_pkg::item_t stage_item  [0:N];
    logic [7:0]      mul_x       [0:N-1];
    logic [7:0]      mul_y       [0:N-1];
    logic            use_xor     [0:N-1];

    // Build the entry beat; flag divide by zero up front.
    always_comb begin
        stage_item[0].func = gfau_pkg::func_t'(s_func);
        stage_item[0].a    = s_operand_a;
        stage_item[0].b    = s_operand_b;
        stage_item[0].acc  = gfau_pkg::GF_ZERO;
        stage_item[0].dz   = (gfau_pkg::func_t'(s_func) == gfau_pkg::FUNC_DIV) &&
                             (s_operand_b == gfau_pkg::GF_ZERO);
    end

    assign stage_valid[0] = s_valid;
    assign s_ready        = stage_ready[0];

    // Pick multiplier operands per stage from the beat entering it.
    always_comb begin
        mul_x[0]   = gfau_pkg::gf_sq(stage_item[0].b);
        mul_y[0]   = stage_item[0].b;
        use_xor[0] = 1'b0;

        mul_x[1]   = gfau_pkg::gf_sq(stage_item[1].acc);
        mul_y[1]   = stage_item[1].b;
        use_xor[1] = 1'b0;

        mul_x[2]   = gfau_pkg::gf_sq(gfau_pkg::gf_sq(gfau_pkg::gf_sq(stage_item[2].acc)));
        mul_y[2]   = stage_item[2].acc;
        use_xor[2] = 1'b0;

        mul_x[3]   = gfau_pkg::gf_sq(stage_item[3].acc);
        mul_y[3]   = stage_item[3].b;
        use_xor[3] = 1'b0;

        // Final stage: reuse the multiplier for multiply and divide.
        mul_x[4] = stage_item[4].a;
        if (stage_item[4].func == gfau_pkg::FUNC_DIV) begin
            mul_y[4] = gfau_pkg::gf_sq(stage_item[4].acc);
        end else begin
            mul_y[4] = stage_item[4].b;
        end
        use_xor[4] = stage_item[4].func inside {gfau_pkg::FUNC_ADD, gfau_pkg::FUNC_SUB};
    end

    for (genvar k = 0; k < N; k++) begin : g_stage
        gfau_stage u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (stage_valid[k]),
            .in_ready  (stage_ready[k]),
            .in_item   (stage_item[k]),
            .mul_x     (mul_x[k]),
            .mul_y     (mul_y[k]),
            .use_xor   (use_xor[k]),
            .out_valid (stage_valid[k+1]),
            .out_ready (stage_ready[k+1]),
            .out_item  (stage_item[k+1])
        );
    end

    // Last stage register is the output register; hold it until the beat is taken.
    assign stage_ready[N]   = m_ready;
    assign m_valid          = stage_valid[N];
    assign m_result         = stage_item[N].acc;
    assign m_divide_by_zero = stage_item[N].dz;

    // A divide-by-zero beat always carries a zero result.
    `GFAU_ASSERT_IMPL(a_dz_zero, m_valid && m_divide_by_zero, m_result == gfau_pkg::GF_ZERO, "divide by zero with nonzero result")
    // Input back-pressure only happens when a result is waiting.
    `GFAU_ASSERT_IMPL(a_stall_source, !s_ready, m_valid && !m_ready, "input stalled without output stall")
    // The inverse chain must invert every nonzero divisor.
    `GFAU_ASSERT_IMPL(a_inverse_ok, stage_valid[4] && (stage_item[4].b != gfau_pkg::GF_ZERO), gfau_pkg::gf_mul(gfau_pkg::gf_sq(stage_item[4].acc), stage_item[4].b) == gfau_pkg::GF_ONE, "inverse chain wrong")
    // A result waiting on back-pressure does not vanish.
    `GFAU_ASSERT_NEXT(a_hold_result, m_valid && !m_ready, m_valid, "stalled result dropped")

endmodule

// ===== hw/rtl/gfau_stage.sv =====
// One pipeline stage of the GF(2^8) unit: a field multiplier or XOR into a register.
// Depends on gfau_pkg.
module gfau_stage (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  gfau_pkg::item_t in_item,
    input  logic [7:0]    mul_x,
    input  logic [7:0]    mul_y,
    input  logic          use_xor,
    output logic          out_valid,
    input  logic          out_ready,
    output gfau_pkg::item_t out_item
);

    logic            valid_reg;
    gfau_pkg::item_t item_reg;
    gfau_pkg::item_t item_next;

    // Advance when this slot is empty or its beat moves on.
    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        item_next = in_item;
        if (use_xor) begin
            item_next.acc = in_item.a ^ in_item.b;
        end else begin
            item_next.acc = gfau_pkg::gf_mul(mul_x, mul_y);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// ===== verif/gf256_arithmetic_unit_tb.sv =====
// Self-checking testbench for gf256_arithmetic_unit: add, subtract, multiply, divide over GF(2^8).
// Depends on gfau_pkg for func_t and the field constants; needs only the RTL to build.
`timescale 1ns / 1ps

module gf256_arithmetic_unit_tb;

    // Cycles without any accepted beat before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 1000;
    // Cycles to keep watching after the last expected beat has arrived.
    localparam int DRAIN_CYCLES   = gfau_pkg::NUM_STAGES * 4;
    // Low byte of the reduction polynomial, used by the shift-and-add multiply.
    localparam logic [7:0] REDUCE_LOW   = gfau_pkg::GF_POLY[7:0];
    // x^254 is the inverse of any nonzero element.
    localparam logic [7:0] INV_EXPONENT = 8'hFE;

    typedef struct packed {
        logic [7:0] result;
        logic       divide_by_zero;
    } field_result_t;

    // Receiver back-pressure modes, each held for a random number of cycles.
    typedef enum logic [1:0] {
        RX_OPEN     = 2'd0,
        RX_RANDOM   = 2'd1,
        RX_PERIODIC = 2'd2,
        RX_BLOCK    = 2'd3
    } rx_mode_t;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [1:0] s_func;
    logic [7:0] s_operand_a;
    logic [7:0] s_operand_b;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_result;
    logic       m_divide_by_zero;

    field_result_t field_results_q[$];
    int            mismatches   = 0;
    int            stall_cycles = 0;

    // Sender burst control.
    int burst_left = 0;
    bit tx_gapless = 0;

    // Receiver stall pattern control.
    rx_mode_t rx_mode      = RX_OPEN;
    int       rx_left      = 0;
    bit       rx_hold_open = 0;

    gf256_arithmetic_unit u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_func           (s_func),
        .s_operand_a      (s_operand_a),
        .s_operand_b      (s_operand_b),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_result         (m_result),
        .m_divide_by_zero (m_divide_by_zero)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Field arithmetic predictor
    // ------------------------------------------------------------------

    // Carry-less shift-and-add multiply; reduce whenever the top bit falls off.
    function automatic logic [7:0] field_product(input logic [7:0] x, input logic [7:0] y);
        logic [7:0] acc;
        logic [7:0] shifted;
        acc     = gfau_pkg::GF_ZERO;
        shifted = x;
        for (int i = 0; i < 8; i++) begin
            if (y[i]) begin
                acc = acc ^ shifted;
            end
            shifted = {shifted[6:0], 1'b0} ^ (shifted[7] ? REDUCE_LOW : gfau_pkg::GF_ZERO);
        end
        return acc;
    endfunction

    // Square-and-multiply for x^254; gives zero for a zero input.
    function automatic logic [7:0] field_reciprocal(input logic [7:0] x);
        logic [7:0] acc;
        logic [7:0] power;
        acc   = gfau_pkg::GF_ONE;
        power = x;
        for (int i = 0; i < 8; i++) begin
            if (INV_EXPONENT[i]) begin
                acc = field_product(acc, power);
            end
            power = field_product(power, power);
        end
        return acc;
    endfunction

    function automatic field_result_t compute_field_op(input gfau_pkg::func_t op,
                                                       input logic [7:0] a,
                                                       input logic [7:0] b);
        field_result_t r;
        r.result         = gfau_pkg::GF_ZERO;
        r.divide_by_zero = 1'b0;
        case (op)
            gfau_pkg::FUNC_ADD, gfau_pkg::FUNC_SUB: begin
                r.result = a ^ b;
            end
            gfau_pkg::FUNC_MUL: begin
                r.result = field_product(a, b);
            end
            default: begin
                // Divide by zero flags and forces a zero result.
                if (b == gfau_pkg::GF_ZERO) begin
                    r.divide_by_zero = 1'b1;
                end else begin
                    r.result = field_product(a, field_reciprocal(b));
                end
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Input side: bursts of beats separated by random idle gaps
    // ------------------------------------------------------------------

    task automatic send_op(input gfau_pkg::func_t op, input logic [7:0] a,
                           input logic [7:0] b);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            // Open a new burst; skip the gap now and then so bursts also run together.
            if (!tx_gapless && $urandom_range(0, 3) != 0) begin
                gap = $urandom_range(1, 8);
            end
            repeat (gap) begin
                @(negedge aclk);
                s_valid     = 1'b0;
                s_func      = 2'($urandom);
                s_operand_a = 8'($urandom);
                s_operand_b = 8'($urandom);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;

        // Drive the beat and hold it, payload unchanged, until accepted.
        @(negedge aclk);
        s_valid     = 1'b1;
        s_func      = op;
        s_operand_a = a;
        s_operand_b = b;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        field_results_q.push_back(compute_field_op(op, a, b));
    endtask

    // Bias operands toward the field extremes.
    function automatic logic [7:0] pick_operand();
        case ($urandom_range(0, 11))
            0:       return gfau_pkg::GF_ZERO;
            1:       return gfau_pkg::GF_ONE;
            2:       return 8'h80;
            3:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Output side: receiver stall pattern, driven at the falling edge
    // ------------------------------------------------------------------

    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(4, 40);
        end
        rx_left--;
        if (rx_hold_open) begin
            m_ready = 1'b1;
        end else begin
            case (rx_mode)
                RX_OPEN:     m_ready = 1'b1;
                RX_RANDOM:   m_ready = 1'($urandom_range(0, 1));
                RX_PERIODIC: m_ready = (rx_left % 3) != 0;
                default:     m_ready = 1'b0;
            endcase
        end
    end

    // Compare every accepted result beat with the oldest expectation.
    always @(posedge aclk) begin
        field_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (field_results_q.size() == 0) begin
                $display("%0t: unexpected result beat, actual result %02h divide_by_zero %0b",
                         $time, m_result, m_divide_by_zero);
                mismatches++;
            end else begin
                want = field_results_q.pop_front();
                if (m_result !== want.result) begin
                    $display("%0t: result mismatch, expected %02h, actual %02h",
                             $time, want.result, m_result);
                    mismatches++;
                end
                if (m_divide_by_zero !== want.divide_by_zero) begin
                    $display("%0t: divide_by_zero mismatch, expected %0b, actual %0b",
                             $time, want.divide_by_zero, m_divide_by_zero);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: end the run if no beat moves on either side for too long.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired with %0d results outstanding",
                         $time, field_results_q.size());
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Add and subtract are both XOR; cover all-zero, all-one and alternating bits.
    task automatic test_add_sub();
        send_op(gfau_pkg::FUNC_ADD, 8'h00, 8'h00);
        send_op(gfau_pkg::FUNC_ADD, 8'hFF, 8'hFF);
        send_op(gfau_pkg::FUNC_ADD, 8'hFF, 8'h00);
        send_op(gfau_pkg::FUNC_ADD, 8'h55, 8'hAA);
        send_op(gfau_pkg::FUNC_SUB, 8'h00, 8'hFF);
        send_op(gfau_pkg::FUNC_SUB, 8'hAA, 8'hAA);
        send_op(gfau_pkg::FUNC_SUB, 8'hFF, 8'h55);
    endtask

    // Multiply by zero and one, and products that need the reduction step.
    task automatic test_multiply();
        send_op(gfau_pkg::FUNC_MUL, 8'h00, 8'hFF);
        send_op(gfau_pkg::FUNC_MUL, 8'hFF, 8'h00);
        send_op(gfau_pkg::FUNC_MUL, 8'h01, 8'hFF);
        send_op(gfau_pkg::FUNC_MUL, 8'h80, 8'h02);
        send_op(gfau_pkg::FUNC_MUL, 8'hFF, 8'hFF);
        send_op(gfau_pkg::FUNC_MUL, 8'h57, 8'h83);
        send_op(gfau_pkg::FUNC_MUL, 8'h80, 8'h80);
    endtask

    // Zero divisor, divisor one, self-division and a zero dividend.
    task automatic test_divide();
        send_op(gfau_pkg::FUNC_DIV, 8'h00, 8'h00);
        send_op(gfau_pkg::FUNC_DIV, 8'hFF, 8'h00);
        send_op(gfau_pkg::FUNC_DIV, 8'hA5, 8'h01);
        send_op(gfau_pkg::FUNC_DIV, 8'h01, 8'h01);
        send_op(gfau_pkg::FUNC_DIV, 8'hFF, 8'hFF);
        send_op(gfau_pkg::FUNC_DIV, 8'h00, 8'h53);
        send_op(gfau_pkg::FUNC_DIV, 8'h01, 8'h53);
        send_op(gfau_pkg::FUNC_DIV, 8'h53, 8'hCA);
    endtask

    // Back-to-back beats with the receiver always ready: one beat per cycle.
    task automatic test_full_rate(input int count);
        tx_gapless   = 1'b1;
        rx_hold_open = 1'b1;
        burst_left   = count;
        repeat (count) begin
            send_op(gfau_pkg::func_t'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
        end
        tx_gapless   = 1'b0;
        rx_hold_open = 1'b0;
        burst_left   = 0;
    endtask

    // Random operations under random gaps and stalls; divide sees a zero divisor often.
    task automatic test_random_mix(input int count);
        gfau_pkg::func_t op;
        logic [7:0]      a;
        logic [7:0]      b;
        repeat (count) begin
            op = gfau_pkg::func_t'($urandom_range(0, 3));
            a  = pick_operand();
            b  = pick_operand();
            if (op == gfau_pkg::FUNC_DIV && $urandom_range(0, 9) == 0) begin
                b = gfau_pkg::GF_ZERO;
            end
            send_op(op, a, b);
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_func      = gfau_pkg::FUNC_ADD;
        s_operand_a = gfau_pkg::GF_ZERO;
        s_operand_b = gfau_pkg::GF_ZERO;
        m_ready     = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_add_sub();
        test_multiply();
        test_divide();
        test_full_rate(48);
        test_random_mix(540);

        // Drop valid after the last beat, then drain the pipeline.
        @(negedge aclk);
        s_valid = 1'b0;
        while (field_results_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0 && field_results_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/gfau_pkg.sv
hw/rtl/gfau_stage.sv
hw/rtl/gf256_arithmetic_unit.sv
verif/gf256_arithmetic_unit_tb.sv
